### rtl/rcpa_pkg.sv
// Shared types and constants of the reference-counted cell pool allocator.
// Depends on nothing; the allocator and its testbench import it.
`timescale 1ns / 1ps

package rcpa_pkg;

    // Pool size and field widths
    localparam int NUM_CELLS = 64;
    localparam int CELL_W    = $clog2(NUM_CELLS);
    localparam int CNT_W     = $clog2(NUM_CELLS + 1);
    localparam int REF_BITS  = 8;
    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    // Request modes
    typedef enum logic [1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_STATS  = 2'd3
    } t_mode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_ALLOC = 2'd2,
        ST_SATURATED = 2'd3
    } t_status;

endpackage

### rtl/rcpa_req_if.sv
// Request channel of the cell pool allocator: valid/ready plus request word.
// Depends on nothing.
`timescale 1ns / 1ps

interface rcpa_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [5:0] cell_index;

    modport source (output valid, output mode, output cell_index, input ready);
    modport sink   (input valid, input mode, input cell_index, output ready);
endinterface

### rtl/rcpa_rsp_if.sv
// Result channel of the cell pool allocator: valid/ready plus result word.
// Depends on nothing.
`timescale 1ns / 1ps

interface rcpa_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [5:0] granted_cell;
    logic       released;
    logic [6:0] used_count;
    logic [6:0] peak_used;

    modport source (output valid, output status, output granted_cell, output released,
                    output used_count, output peak_used, input ready);
    modport sink   (input valid, input status, input granted_cell, input released,
                    input used_count, input peak_used, output ready);
endinterface

### rtl/refcounted_cell_pool_allocator.sv
// Reference-counted cell pool allocator: FIFO free ring plus per-cell counts.
// Depends on rcpa_pkg, rcpa_req_if and rcpa_rsp_if.
//
//   channel  | dir | word
//   ---------+-----+----------------------------------------------------
//   i_req    | in  | mode, cell_index
//   o_rsp    | out | status, granted_cell, released, used_count, peak_used
//
// One word per cycle sustained while results are taken; a request is registered in
// the read stage, then its result in the result register. The read stage reads the
// free ring and count memories, the decide stage decides and writes them back, with
// write-first bypass toward the next word's read. Reset is usable at once: per-entry
// valid bits stand in for the initial ring contents and zero counts. A stalled result
// holds the decide stage, while the read stage still takes a word when it is empty.
`timescale 1ns / 1ps

module refcounted_cell_pool_allocator
    import rcpa_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    rcpa_req_if.sink     i_req,
    rcpa_rsp_if.source   o_rsp
);

    // Memories and their valid bits
    logic [CELL_W-1:0]   ring_mem [NUM_CELLS];
    logic [REF_BITS-1:0] ref_mem  [NUM_CELLS];
    logic [NUM_CELLS-1:0] r_ring_vld;
    logic [NUM_CELLS-1:0] r_ref_vld;

    // Read stage registers
    logic                r_s1_valid;
    t_mode               r_s1_mode;
    logic [CELL_W-1:0]   r_s1_idx;
    logic [REF_BITS-1:0] r_rc_mem;
    logic [REF_BITS-1:0] r_rc_byp;
    logic                r_rc_use_mem;
    logic [CELL_W-1:0]   r_ring_mem;
    logic [CELL_W-1:0]   r_ring_byp;
    logic                r_ring_use_mem;

    // Architectural state
    logic [CELL_W-1:0] r_free_head, n_free_head;
    logic [CELL_W-1:0] r_free_tail, n_free_tail;
    logic [CNT_W-1:0]  r_free_count, n_free_count;
    logic [CNT_W-1:0]  r_in_use, n_in_use;
    logic [CNT_W-1:0]  r_peak, n_peak;

    // Result register
    logic              r_out_valid;
    t_status           r_out_status, n_out_status;
    logic [CELL_W-1:0] r_out_granted, n_out_granted;
    logic              r_out_released, n_out_released;
    logic [CNT_W-1:0]  r_out_used;
    logic [CNT_W-1:0]  r_out_peak;

    // Write ports
    logic                ref_we;
    logic [CELL_W-1:0]   ref_waddr;
    logic [REF_BITS-1:0] ref_wdata;
    logic                ring_we;

    logic                fire2;
    logic                in_fire;
    logic [REF_BITS-1:0] rc;
    logic [CELL_W-1:0]   head_cell;

    // Handshake
    assign fire2       = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || fire2;
    assign in_fire     = i_req.valid && i_req.ready;

    // Effective read data: memory when written, bypass or reset value otherwise
    assign rc        = r_rc_use_mem   ? r_rc_mem   : r_rc_byp;
    assign head_cell = r_ring_use_mem ? r_ring_mem : r_ring_byp;

    // Ring position advance with wrap
    function automatic logic [CELL_W-1:0] ring_next(input logic [CELL_W-1:0] pos);
        ring_next = (pos == CELL_W'(NUM_CELLS - 1)) ? '0 : pos + 1'b1;
    endfunction

    // Decide stage: status, memory writes, next pointers and counters.
    // cell_index always fits the pool, so no range check is needed.
    always_comb begin
        n_free_head    = r_free_head;
        n_free_tail    = r_free_tail;
        n_free_count   = r_free_count;
        n_in_use       = r_in_use;
        n_peak         = r_peak;
        n_out_status   = ST_OK;
        n_out_granted  = '0;
        n_out_released = 1'b0;
        ref_we         = 1'b0;
        ref_waddr      = r_s1_idx;
        ref_wdata      = rc;
        ring_we        = 1'b0;
        if (fire2) begin
            case (r_s1_mode)
                MODE_ALLOC: begin
                    if (r_free_count == '0) begin
                        n_out_status = ST_EMPTY;
                    end else begin
                        n_out_granted = head_cell;
                        n_free_head   = ring_next(r_free_head);
                        n_free_count  = r_free_count - 1'b1;
                        ref_we        = 1'b1;
                        ref_waddr     = head_cell;
                        ref_wdata     = REF_BITS'(1);
                        n_in_use      = r_in_use + 1'b1;
                        if (n_in_use > r_peak) begin
                            n_peak = n_in_use;
                        end
                    end
                end
                MODE_ADD: begin
                    if (rc == '0) begin
                        n_out_status = ST_NOT_ALLOC;
                    end else if (rc == REF_MAX) begin
                        n_out_status = ST_SATURATED;
                    end else begin
                        ref_we    = 1'b1;
                        ref_wdata = rc + 1'b1;
                    end
                end
                MODE_REMOVE: begin
                    if (rc == '0) begin
                        n_out_status = ST_NOT_ALLOC;
                    end else begin
                        ref_we    = 1'b1;
                        ref_wdata = rc - 1'b1;
                        // last reference gone: back to the ring tail
                        if (rc == REF_BITS'(1)) begin
                            ring_we        = 1'b1;
                            n_free_tail    = ring_next(r_free_tail);
                            n_out_released = 1'b1;
                            if (r_free_count < CNT_W'(NUM_CELLS)) begin
                                n_free_count = r_free_count + 1'b1;
                            end
                            if (r_in_use != '0) begin
                                n_in_use = r_in_use - 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    n_out_status = ST_OK;
                end
            endcase
        end
    end

    // Memory writes
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_mem[r_free_tail] <= r_s1_idx;
        end
        if (ref_we) begin
            ref_mem[ref_waddr] <= ref_wdata;
        end
    end

    // Memory reads for the incoming word, bypassing a same-cycle write
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_mode      <= t_mode'(i_req.mode);
            r_s1_idx       <= i_req.cell_index;
            r_rc_mem       <= ref_mem[i_req.cell_index];
            r_ring_mem     <= ring_mem[n_free_head];
            if (ref_we && ref_waddr == i_req.cell_index) begin
                r_rc_byp     <= ref_wdata;
                r_rc_use_mem <= 1'b0;
            end else begin
                r_rc_byp     <= '0;
                r_rc_use_mem <= r_ref_vld[i_req.cell_index];
            end
            if (ring_we && r_free_tail == n_free_head) begin
                r_ring_byp     <= r_s1_idx;
                r_ring_use_mem <= 1'b0;
            end else begin
                r_ring_byp     <= n_free_head;
                r_ring_use_mem <= r_ring_vld[n_free_head];
            end
        end
    end

    // Control state, valid bits and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_ring_vld   <= '0;
            r_ref_vld    <= '0;
            r_free_head  <= '0;
            r_free_tail  <= '0;
            r_free_count <= CNT_W'(NUM_CELLS);
            r_in_use     <= '0;
            r_peak       <= '0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (fire2) begin
                r_s1_valid <= 1'b0;
            end
            if (fire2) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (ring_we) begin
                r_ring_vld[r_free_tail] <= 1'b1;
            end
            if (ref_we) begin
                r_ref_vld[ref_waddr] <= 1'b1;
            end
            r_free_head  <= n_free_head;
            r_free_tail  <= n_free_tail;
            r_free_count <= n_free_count;
            r_in_use     <= n_in_use;
            r_peak       <= n_peak;
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (fire2) begin
            r_out_status   <= n_out_status;
            r_out_granted  <= n_out_granted;
            r_out_released <= n_out_released;
            r_out_used     <= n_in_use;
            r_out_peak     <= n_peak;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.granted_cell = r_out_granted;
    assign o_rsp.released     = r_out_released;
    assign o_rsp.used_count   = r_out_used;
    assign o_rsp.peak_used    = r_out_peak;

endmodule

### tb/refcounted_cell_pool_allocator_test.sv
// Self-checking testbench for the reference-counted cell pool allocator.
// Depends on rcpa_pkg, rcpa_req_if, rcpa_rsp_if and refcounted_cell_pool_allocator.
`timescale 1ns / 1ps

module refcounted_cell_pool_allocator_test
    import rcpa_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_WORDS = 650;

    // Expected result word, field widths as on the result channel
    typedef struct packed {
        t_status             status;
        logic [CELL_W-1:0]   granted_cell;
        logic                released;
        logic [CNT_W-1:0]    used_count;
        logic [CNT_W-1:0]    peak_used;
    } t_pool_rsp;

    logic i_clk;
    logic i_rst_n;

    rcpa_req_if req_ch ();
    rcpa_rsp_if rsp_ch ();

    refcounted_cell_pool_allocator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow of the pool: free ring, per-cell counts, usage
    logic [CELL_W-1:0]   shadow_ring [NUM_CELLS];
    logic [REF_BITS-1:0] shadow_refs [NUM_CELLS];
    int                  ring_head;
    int                  ring_tail;
    int                  free_cells;
    int                  used_cells;
    int                  peak_cells;
    logic [CELL_W-1:0]   last_grant;

    t_pool_rsp pending_rsp [$];

    // Run bookkeeping
    int   err_cnt;
    int   words_sent;
    int   words_checked;
    int   n_grants;
    int   n_releases;
    int   n_empty;
    int   n_not_alloc;
    int   n_saturated;
    int   cycle_cnt;
    bit   holding;
    bit   quiet;
    bit   filling;
    event hold_start;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle limit
    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time, pending_rsp.size());
            $display("refcounted_cell_pool_allocator test failed");
            $finish;
        end
    end

    // Receiver hold-off, counted in cycles once started
    initial begin
        holding = 1'b0;
        forever begin
            @(hold_start);
            holding = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            holding = 1'b0;
        end
    end

    // Result ready: long hold-off, random stalls, or always ready when quiet
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holding)
                rsp_ch.ready = 1'b0;
            else if (!quiet && $urandom_range(99) < 16)
                rsp_ch.ready = 1'b0;
            else
                rsp_ch.ready = 1'b1;
        end
    end

    // Pool predictor: apply one request to the shadow state
    function automatic t_pool_rsp pool_step(t_mode m, logic [CELL_W-1:0] idx);
        t_pool_rsp         r;
        logic [CELL_W-1:0] grant_idx;
        bit                known;
        r = '0;
        r.status = ST_OK;
        known = int'(idx) < NUM_CELLS;
        case (m)
            MODE_ALLOC: begin
                if (free_cells == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    grant_idx = shadow_ring[ring_head];
                    ring_head = (ring_head + 1) % NUM_CELLS;
                    free_cells--;
                    shadow_refs[grant_idx] = REF_BITS'(1);
                    r.granted_cell = grant_idx;
                    last_grant = grant_idx;
                    used_cells++;
                    if (used_cells > peak_cells) peak_cells = used_cells;
                end
            end
            MODE_ADD: begin
                if (!known || shadow_refs[idx] == 0)
                    r.status = ST_NOT_ALLOC;
                else if (shadow_refs[idx] == REF_MAX)
                    r.status = ST_SATURATED;
                else
                    shadow_refs[idx]++;
            end
            MODE_REMOVE: begin
                if (!known || shadow_refs[idx] == 0) begin
                    r.status = ST_NOT_ALLOC;
                end else begin
                    shadow_refs[idx]--;
                    if (shadow_refs[idx] == 0) begin
                        shadow_ring[ring_tail] = idx;
                        ring_tail = (ring_tail + 1) % NUM_CELLS;
                        if (free_cells < NUM_CELLS) free_cells++;
                        if (used_cells > 0) used_cells--;
                        r.released = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.used_count = CNT_W'(used_cells);
        r.peak_used = CNT_W'(peak_cells);
        case (r.status)
            ST_OK:        if (m == MODE_ALLOC) n_grants++;
            ST_EMPTY:     n_empty++;
            ST_NOT_ALLOC: n_not_alloc++;
            default:      n_saturated++;
        endcase
        if (r.released) n_releases++;
        return r;
    endfunction

    // Random live cell, or any cell if none is allocated
    function automatic logic [CELL_W-1:0] pick_live_cell();
        int start;
        int k;
        start = $urandom_range(NUM_CELLS - 1);
        for (k = 0; k < NUM_CELLS; k++) begin
            if (shadow_refs[(start + k) % NUM_CELLS] != 0)
                return CELL_W'((start + k) % NUM_CELLS);
        end
        return CELL_W'(start);
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            err_cnt++;
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_pool_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            words_checked++;
            if (pending_rsp.size() == 0) begin
                err_cnt++;
                $display("%0t unexpected result word: status %0d cell %0d used %0d",
                         $time, rsp_ch.status, rsp_ch.granted_cell, rsp_ch.used_count);
            end else begin
                want = pending_rsp.pop_front();
                check_field("status", want.status, rsp_ch.status);
                check_field("granted_cell", want.granted_cell, rsp_ch.granted_cell);
                check_field("released", want.released, rsp_ch.released);
                check_field("used_count", want.used_count, rsp_ch.used_count);
                check_field("peak_used", want.peak_used, rsp_ch.peak_used);
            end
        end
    end

    // Offer one request word, with random idle cycles ahead of it
    task automatic send_word(input t_mode m, input logic [CELL_W-1:0] idx);
        t_pool_rsp want;
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 16) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.mode = m;
        req_ch.cell_index = idx;
        req_ch.valid = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        want = pool_step(m, idx);
        pending_rsp = {pending_rsp, want};
        words_sent++;
    endtask

    // Sender goes quiet until every expected result has come back
    task automatic drain_results();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic on live cells, some noise
    task automatic random_request();
        int unsigned       roll;
        int unsigned       alloc_pct;
        t_mode             m;
        logic [CELL_W-1:0] idx;
        roll = $urandom_range(99);
        idx = CELL_W'($urandom_range(NUM_CELLS - 1));
        if (roll < 10) begin
            m = t_mode'(2'($urandom_range(3)));
        end else if (roll < 13) begin
            m = MODE_STATS;
        end else begin
            alloc_pct = filling ? 55 : 20;
            roll = $urandom_range(99);
            if (roll < alloc_pct) begin
                m = MODE_ALLOC;
            end else if (roll < alloc_pct + (100 - alloc_pct) / 3) begin
                m = MODE_ADD;
                idx = pick_live_cell();
            end else begin
                m = MODE_REMOVE;
                idx = pick_live_cell();
            end
        end
        send_word(m, idx);
        if (used_cells == NUM_CELLS)
            filling = 1'b0;
        else if (used_cells == 0)
            filling = 1'b1;
        else if ($urandom_range(63) == 0)
            filling = !filling;
    endtask

    // Requests straight out of reset, including misuse of free cells
    task automatic test_reset_state();
        send_word(MODE_STATS, '1);
        send_word(MODE_REMOVE, '0);
        send_word(MODE_ADD, CELL_W'(NUM_CELLS - 1));
    endtask

    // Every mode on a couple of cells, release and reuse order
    task automatic test_basic_ops();
        send_word(MODE_ALLOC, '1);
        send_word(MODE_ALLOC, '0);
        send_word(MODE_ADD, '0);
        send_word(MODE_ADD, '0);
        send_word(MODE_REMOVE, '0);
        send_word(MODE_REMOVE, '0);
        send_word(MODE_REMOVE, '0);
        send_word(MODE_ADD, '0);
        send_word(MODE_REMOVE, '0);
        send_word(MODE_ALLOC, 6'h2a);
        send_word(MODE_REMOVE, CELL_W'(1));
        send_word(MODE_STATS, 6'h15);
    endtask

    // Fill the pool to empty, allocate past it, then free everything
    task automatic test_pool_empty();
        while (free_cells > 0)
            send_word(MODE_ALLOC, CELL_W'($urandom_range(NUM_CELLS - 1)));
        send_word(MODE_ALLOC, '0);
        send_word(MODE_ALLOC, '1);
        send_word(MODE_STATS, '0);
        send_word(MODE_ADD, CELL_W'(NUM_CELLS - 1));
        send_word(MODE_REMOVE, CELL_W'(NUM_CELLS - 1));
        while (used_cells > 0)
            send_word(MODE_REMOVE, pick_live_cell());
        send_word(MODE_STATS, '1);
    endtask

    // Drive one count to its ceiling and back down to release
    task automatic test_saturation();
        logic [CELL_W-1:0] sat_idx;
        send_word(MODE_ALLOC, '0);
        sat_idx = last_grant;
        repeat (int'(REF_MAX) - 1) send_word(MODE_ADD, sat_idx);
        send_word(MODE_ADD, sat_idx);
        send_word(MODE_ADD, sat_idx);
        send_word(MODE_REMOVE, sat_idx);
        send_word(MODE_ADD, sat_idx);
        repeat (int'(REF_MAX)) send_word(MODE_REMOVE, sat_idx);
        send_word(MODE_REMOVE, sat_idx);
    endtask

    // Receiver stalls for a long stretch while requests keep coming
    task automatic test_backpressure();
        @(negedge i_clk);
        -> hold_start;
        repeat (40) random_request();
    endtask

    // Random traffic with a stretch of no idling on either side
    task automatic test_random(input int n_words);
        int k;
        for (k = 0; k < n_words; k++) begin
            quiet = (k >= n_words / 3) && (k < n_words / 3 + 200);
            random_request();
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_ALLOC;
        req_ch.cell_index = '0;
        quiet = 1'b0;
        filling = 1'b1;
        err_cnt = 0;
        words_sent = 0;
        words_checked = 0;
        n_grants = 0;
        n_releases = 0;
        n_empty = 0;
        n_not_alloc = 0;
        n_saturated = 0;
        last_grant = '0;
        for (int i = 0; i < NUM_CELLS; i++) begin
            shadow_ring[i] = CELL_W'(i);
            shadow_refs[i] = '0;
        end
        ring_head = 0;
        ring_tail = 0;
        free_cells = NUM_CELLS;
        used_cells = 0;
        peak_cells = 0;

        // Synchronous reset, released on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_basic_ops();
        drain_results();
        test_pool_empty();
        drain_results();
        test_saturation();
        drain_results();
        test_backpressure();
        drain_results();
        test_random(RANDOM_WORDS);
        drain_results();

        // Let any stray word show up after the last expected one
        repeat (10) @(posedge i_clk);

        $display("Sent %0d requests, checked %0d result words, %0d mismatches",
                 words_sent, words_checked, err_cnt);
        $display("Grants %0d, releases %0d, empty pool %0d, free-cell misuse %0d, saturated %0d",
                 n_grants, n_releases, n_empty, n_not_alloc, n_saturated);
        if (err_cnt == 0)
            $display("refcounted_cell_pool_allocator test passed");
        else
            $display("refcounted_cell_pool_allocator test failed");
        $finish;
    end

endmodule
